// ===== src/scalc_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the stack calculator.
package scalc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 5;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 4;
    localparam int ST_W        = 2;
    localparam int CNT_W       = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [SP_W-1:0]   t_sp;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_op OP_PUSH   = 4'd0;
    localparam t_op OP_POP    = 4'd1;
    localparam t_op OP_ADD    = 4'd2;
    localparam t_op OP_SUB    = 4'd3;
    localparam t_op OP_MUL    = 4'd4;
    localparam t_op OP_DIV    = 4'd5;
    localparam t_op OP_GT     = 4'd6;
    localparam t_op OP_GE     = 4'd7;
    localparam t_op OP_LT     = 4'd8;
    localparam t_op OP_LE     = 4'd9;
    localparam t_op OP_EQ     = 4'd10;
    localparam t_op OP_DUP    = 4'd11;
    localparam t_op OP_DIVMOD = 4'd12;
    localparam t_op OP_SWAP   = 4'd13;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_UNDER = 2'd1;
    localparam t_status ST_OVER  = 2'd2;
    localparam t_status ST_DIVZ  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch a new item
        logic ex;     // evaluate the item on the fetched operands
        logic wb1;    // first stack write, pointer update
        logic wb2;    // second stack write
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_div;    // item needs the divider (valid during evaluate)
        logic two_wr;    // item writes two entries
        logic div_done;  // divider result ready
    } t_stat;

endpackage

// ===== src/scalc_div.sv =====
// Iterative restoring signed divider, one quotient bit per cycle.
module scalc_div import scalc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_quo,
    output t_word o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_quo;
    t_word            r_rem;
    t_word            r_den;
    logic             r_qneg;
    logic             r_rneg;

    logic [DATA_W:0]   n_rem_sh;
    logic [DATA_W+1:0] n_diff;

    assign n_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign n_diff   = {1'b0, n_rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_num[DATA_W-1] ? (t_word'(0) - i_num) : i_num;
            r_den  <= i_den[DATA_W-1] ? (t_word'(0) - i_den) : i_den;
            r_rem  <= '0;
            r_qneg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_rneg <= i_num[DATA_W-1];
        end else if (r_busy) begin
            if (!n_diff[DATA_W+1]) begin
                r_rem <= n_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_qneg ? (t_word'(0) - r_quo) : r_quo;
    assign o_rem  = r_rneg ? (t_word'(0) - r_rem) : r_rem;

endmodule

// ===== src/scalc_dp.sv =====
// Datapath: stack memory, pointer, operand registers, ALU and result registers.
module scalc_dp import scalc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  t_op     i_op,
    input  t_word   i_push_value,
    output t_word   o_emitted_value,
    output logic    o_emitted_valid,
    output t_status o_status,
    output logic [DEPTH_W-1:0] o_depth
);

    t_word r_mem [STACK_DEPTH];

    t_op     r_op;
    t_word   r_pv;
    t_sp     r_sp;
    t_sp     r_sp_nx;
    t_word   r_n1;
    t_word   r_n2;
    t_word   r_emit;
    logic    r_valid;
    t_status r_status;
    logic    r_w1_en;
    t_addr   r_w1_addr;
    t_word   r_w1_data;
    logic    r_w2_en;
    t_addr   r_w2_addr;
    t_word   r_w2_data;

    t_addr   a_top;
    t_addr   a_m1;
    t_addr   a_m2;
    t_sp     sp_m1;
    t_sp     sp_m2;
    logic    full;
    logic [1:0] need;

    t_status n_status;
    t_word   n_emit;
    logic    n_valid;
    t_sp     n_sp;
    logic    n_w1_en;
    t_addr   n_w1_addr;
    t_word   n_w1_data;
    logic    n_w2_en;
    t_addr   n_w2_addr;
    t_word   n_w2_data;
    logic    n_go_div;
    t_word   alu;

    logic    div_done;
    t_word   div_quo;
    t_word   div_rem;

    logic    wr_en;
    t_addr   wr_addr;
    t_word   wr_data;

    assign sp_m1 = r_sp - SP_W'(1);
    assign sp_m2 = r_sp - SP_W'(2);
    assign a_top = r_sp[ADDR_W-1:0];
    assign a_m1  = sp_m1[ADDR_W-1:0];
    assign a_m2  = sp_m2[ADDR_W-1:0];
    assign full  = (r_sp == SP_W'(STACK_DEPTH));

    // binary ALU, n2 op n1
    always_comb begin
        case (r_op)
            OP_ADD:  alu = r_n2 + r_n1;
            OP_SUB:  alu = r_n2 - r_n1;
            OP_MUL:  alu = r_n2 * r_n1;
            OP_GT:   alu = t_word'($signed(r_n2) >  $signed(r_n1));
            OP_GE:   alu = t_word'($signed(r_n2) >= $signed(r_n1));
            OP_LT:   alu = t_word'($signed(r_n2) <  $signed(r_n1));
            OP_LE:   alu = t_word'($signed(r_n2) <= $signed(r_n1));
            OP_EQ:   alu = t_word'(r_n2 == r_n1);
            default: alu = '0;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_PUSH:        need = 2'd0;
            OP_POP, OP_DUP: need = 2'd1;
            default:        need = 2'd2;
        endcase
    end

    // item evaluation on fetched operands
    always_comb begin
        n_status  = ST_OK;
        n_emit    = '0;
        n_valid   = 1'b0;
        n_sp      = r_sp;
        n_w1_en   = 1'b0;
        n_w1_addr = a_m2;
        n_w1_data = alu;
        n_w2_en   = 1'b0;
        n_w2_addr = a_m1;
        n_w2_data = r_n2;
        n_go_div  = 1'b0;
        if (r_op > OP_SWAP) begin
            // unused opcode: no effect
        end else if (r_sp < SP_W'(need)) begin
            n_status = ST_UNDER;
        end else begin
            case (r_op)
                OP_PUSH: begin
                    if (full) begin
                        n_status = ST_OVER;
                    end else begin
                        n_w1_en   = 1'b1;
                        n_w1_addr = a_top;
                        n_w1_data = r_pv;
                        n_sp      = r_sp + SP_W'(1);
                    end
                end
                OP_POP: begin
                    n_emit  = r_n1;
                    n_valid = 1'b1;
                    n_sp    = sp_m1;
                end
                OP_DUP: begin
                    if (full) begin
                        n_status = ST_OVER;
                    end else begin
                        n_w1_en   = 1'b1;
                        n_w1_addr = a_top;
                        n_w1_data = r_n1;
                        n_sp      = r_sp + SP_W'(1);
                    end
                end
                OP_SWAP: begin
                    n_w1_en   = 1'b1;
                    n_w1_data = r_n1;
                    n_w2_en   = 1'b1;
                end
                OP_DIV, OP_DIVMOD: begin
                    if (r_n1 == '0) begin
                        n_status = ST_DIVZ;
                    end else begin
                        n_go_div = 1'b1;
                        n_w1_en  = 1'b1;
                        n_w2_en  = (r_op == OP_DIVMOD);
                        n_sp     = (r_op == OP_DIV) ? sp_m1 : r_sp;
                    end
                end
                default: begin
                    n_w1_en = 1'b1;
                    n_sp    = sp_m1;
                end
            endcase
        end
    end

    scalc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ex & n_go_div),
        .i_num   (r_n2),
        .i_den   (r_n1),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_w1_en <= 1'b0;
            r_w2_en <= 1'b0;
        end else begin
            if (i_cmd.ex) begin
                r_w1_en <= n_w1_en;
                r_w2_en <= n_w2_en;
            end
            if (i_cmd.wb1) begin
                r_sp <= r_sp_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_pv <= i_push_value;
        end
        if (i_cmd.ex) begin
            r_status  <= n_status;
            r_emit    <= n_emit;
            r_valid   <= n_valid;
            r_sp_nx   <= n_sp;
            r_w1_addr <= n_w1_addr;
            r_w1_data <= n_w1_data;
            r_w2_addr <= n_w2_addr;
            r_w2_data <= n_w2_data;
        end else if (div_done) begin
            // div keeps the quotient; divmod stores remainder below quotient
            r_w1_data <= (r_op == OP_DIVMOD) ? div_rem : div_quo;
            r_w2_data <= div_quo;
        end
    end

    // stack memory: one write port, two registered read ports
    assign wr_en   = (i_cmd.wb1 & r_w1_en) | (i_cmd.wb2 & r_w2_en);
    assign wr_addr = i_cmd.wb2 ? r_w2_addr : r_w1_addr;
    assign wr_data = i_cmd.wb2 ? r_w2_data : r_w1_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_n1 <= r_mem[a_m1];
        r_n2 <= r_mem[a_m2];
    end

    assign o_stat.go_div   = n_go_div;
    assign o_stat.two_wr   = r_w2_en;
    assign o_stat.div_done = div_done;

    assign o_emitted_value = r_emit;
    assign o_emitted_valid = r_valid;
    assign o_status        = r_status;
    assign o_depth         = DEPTH_W'(r_sp);

endmodule

// ===== src/scalc_ctrl.sv =====
// Controller state machine: sequences fetch, evaluate, divide, write back and respond.
module scalc_ctrl import scalc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output logic  o_done,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_DV   = 3'd3;
    localparam logic [2:0] S_WB1  = 3'd4;
    localparam logic [2:0] S_WB2  = 3'd5;
    localparam logic [2:0] S_RSP  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_RD;
            S_RD:   n_state = S_EX;
            S_EX:   n_state = i_stat.go_div ? S_DV : S_WB1;
            S_DV:   if (i_stat.div_done) n_state = S_WB1;
            S_WB1:  n_state = i_stat.two_wr ? S_WB2 : S_RSP;
            S_WB2:  n_state = S_RSP;
            S_RSP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = (r_state == S_RSP);
    assign o_cmd.load = (r_state == S_IDLE) & start;
    assign o_cmd.ex   = (r_state == S_EX);
    assign o_cmd.wb1  = (r_state == S_WB1);
    assign o_cmd.wb2  = (r_state == S_WB2);

endmodule

// ===== src/stack_calculator_alu.sv =====
// Top level of the stack calculator: controller plus datapath.
// One item at a time. Non-divide items step through fetch, evaluate, write and result
// before the o_done strobe, swap adds a second write; div and divmod add the divider
// steps and its done, divmod also a second write. The divider sets the worst case.
// busy drops the cycle after the o_done strobe; only then is a new item taken.
// Synchronous active-low reset empties the stack; stored entries are not cleared.
module stack_calculator_alu import scalc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_op     i_op,
    input  t_word   i_push_value,
    output logic    o_done,
    output t_word   o_emitted_value,
    output logic    o_emitted_valid,
    output t_status o_status,
    output logic [DEPTH_W-1:0] o_depth
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing: IDLE -> RD -> EX -> [DV] -> WB1 -> [WB2] -> RSP
    scalc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // stack memory, operands, ALU, divider and held result fields
    scalc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_push_value    (i_push_value),
        .o_emitted_value (o_emitted_value),
        .o_emitted_valid (o_emitted_valid),
        .o_status        (o_status),
        .o_depth         (o_depth)
    );

endmodule

// ===== src/scalc_checker.sv =====
// Port-level checks for the stack calculator, bound to the top level.
module scalc_checker import scalc_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input logic    o_emitted_valid,
    input t_status o_status
);

    // accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only appears for an item in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result while idle");

    // busy ends only right after the result strobe
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without result");

    // a popped value means the command succeeded
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_emitted_valid) |-> (o_status == ST_OK))
        else $error("emitted value with error status");

endmodule

bind stack_calculator_alu scalc_checker u_scalc_checker (.*);

// ===== sim/tb_stack_calculator_alu.sv =====
// Self-checking testbench for the stack calculator core: directed and random commands.
module tb_stack_calculator_alu;
    import scalc_pkg::*;

    // Opcodes the block leaves unused; they must act as no-ops.
    localparam t_op   OP_SPARE_A = 4'd14;
    localparam t_op   OP_SPARE_B = 4'd15;
    localparam t_word WORD_MIN   = 32'h8000_0000;
    localparam t_word WORD_MAX   = 32'h7fff_ffff;
    localparam t_word WORD_M1    = 32'hffff_ffff;
    localparam int    RANDOM_CMDS = 420;
    localparam int    CALM_TAIL   = 100;   // last commands go without sender gaps
    localparam int    DRAIN_WAIT  = 60;    // beyond the divider path

    // Fields of one result item.
    typedef struct {
        t_word               emitted_value;
        logic                emitted_valid;
        t_status             status;
        logic [DEPTH_W-1:0]  depth;
    } calc_result_t;

    // Scoreboard: mirrors the stack, predicts each command's result and
    // checks results in order.
    class stack_mirror;
        t_word        stack_words [STACK_DEPTH];
        int unsigned  entries;
        calc_result_t awaited_results [$];
        int unsigned  mismatches;

        function new();
            entries    = 0;
            mismatches = 0;
        endfunction

        function void note_command(t_op op, t_word value);
            calc_result_t res;
            int unsigned  need;
            t_word        top, below, mag_n, mag_d, quo, rem, word;
            res.emitted_value = '0;
            res.emitted_valid = 1'b0;
            res.status        = ST_OK;
            need = 0;
            if (op == OP_POP || op == OP_DUP)
                need = 1;
            else if (op >= OP_ADD && op <= OP_SWAP)
                need = 2;

            if (op > OP_SWAP) begin
                // spare opcode: nothing changes
            end else if (entries < need) begin
                res.status = ST_UNDER;
            end else if (op == OP_PUSH) begin
                if (entries >= STACK_DEPTH) res.status = ST_OVER;
                else begin
                    stack_words[entries] = value;
                    entries++;
                end
            end else if (op == OP_POP) begin
                entries--;
                res.emitted_value = stack_words[entries];
                res.emitted_valid = 1'b1;
            end else if (op == OP_DUP) begin
                if (entries >= STACK_DEPTH) res.status = ST_OVER;
                else begin
                    stack_words[entries] = stack_words[entries-1];
                    entries++;
                end
            end else begin
                top   = stack_words[entries-1];
                below = stack_words[entries-2];
                // truncating divide on magnitudes, signs fixed up after
                mag_n = below[DATA_W-1] ? -below : below;
                mag_d = top[DATA_W-1] ? -top : top;
                quo   = (mag_d != 0) ? mag_n / mag_d : '0;
                rem   = (mag_d != 0) ? mag_n % mag_d : '0;
                if (below[DATA_W-1] != top[DATA_W-1]) quo = -quo;
                if (below[DATA_W-1]) rem = -rem;
                if ((op == OP_DIV || op == OP_DIVMOD) && top == '0) begin
                    res.status = ST_DIVZ;
                end else if (op == OP_DIVMOD) begin
                    stack_words[entries-2] = rem;
                    stack_words[entries-1] = quo;
                end else if (op == OP_SWAP) begin
                    stack_words[entries-2] = top;
                    stack_words[entries-1] = below;
                end else begin
                    case (op)
                        OP_ADD:  word = below + top;
                        OP_SUB:  word = below - top;
                        OP_MUL:  word = below * top;
                        OP_DIV:  word = quo;
                        OP_GT:   word = ($signed(below) >  $signed(top)) ? 1 : 0;
                        OP_GE:   word = ($signed(below) >= $signed(top)) ? 1 : 0;
                        OP_LT:   word = ($signed(below) <  $signed(top)) ? 1 : 0;
                        OP_LE:   word = ($signed(below) <= $signed(top)) ? 1 : 0;
                        default: word = (below == top) ? 1 : 0;
                    endcase
                    stack_words[entries-2] = word;
                    entries--;
                end
            end
            res.depth = entries[DEPTH_W-1:0];
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string name, t_word want, t_word got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(calc_result_t got);
            calc_result_t want;
            if (awaited_results.size() == 0) begin
                $error("result strobe with no command outstanding");
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("emitted_value", want.emitted_value, got.emitted_value);
            compare_field("emitted_valid", t_word'(want.emitted_valid),
                          t_word'(got.emitted_valid));
            compare_field("status", t_word'(want.status), t_word'(got.status));
            compare_field("depth", t_word'(want.depth), t_word'(got.depth));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_op                i_op = OP_PUSH;
    t_word              i_push_value = '0;
    logic               o_done;
    t_word              o_emitted_value;
    logic               o_emitted_valid;
    t_status            o_status;
    logic [DEPTH_W-1:0] o_depth;

    stack_mirror mirror = new();

    stack_calculator_alu dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_push_value    (i_push_value),
        .o_done          (o_done),
        .o_emitted_value (o_emitted_value),
        .o_emitted_valid (o_emitted_valid),
        .o_status        (o_status),
        .o_depth         (o_depth)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Results cannot be held off: take every strobe as it comes.
    always @(posedge i_clk) begin
        calc_result_t got;
        if (o_done) begin
            got.emitted_value = o_emitted_value;
            got.emitted_valid = o_emitted_valid;
            got.status        = o_status;
            got.depth         = o_depth;
            mirror.check_result(got);
        end
    end

    // Present one command and hold it until the block takes it. The item is
    // taken at the first edge with busy low. An optional sender gap follows.
    task automatic send_command(input t_op op, input t_word value, input bit may_idle);
        start        <= 1'b1;
        i_op         <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (busy);
        mirror.note_command(op, value);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (mirror.awaited_results.size() != 0);
    endtask

    // Values lean toward the corners: zero (divide by zero, equality),
    // small magnitudes, and the signed extremes.
    function automatic t_word pick_value();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 4))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return WORD_M1;
                    3: return 1;
                    default: return 0;
                endcase
            end
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal commands given the mirrored depth; a little noise.
    function automatic t_op pick_op(int unsigned depth_now);
        t_op binary_ops [11] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_GE,
                                 OP_LT, OP_LE, OP_EQ, OP_DIVMOD, OP_SWAP};
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return t_op'($urandom_range(0, 15));
        if (depth_now < 2 && r < 80)
            return OP_PUSH;
        if (r < 35)
            return OP_PUSH;
        if (r < 45)
            return OP_POP;
        if (r < 55)
            return OP_DUP;
        return binary_ops[$urandom_range(0, 10)];
    endfunction

    initial begin
        int unsigned n;
        t_op         op;
        t_word       value;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: underflow on an empty or short stack, spare opcodes,
        // most negative over minus one, divide by zero, each operation.
        send_command(OP_POP, 0, 0);
        send_command(OP_ADD, 0, 0);
        send_command(OP_DUP, 0, 0);
        send_command(OP_SPARE_A, WORD_M1, 0);
        send_command(OP_PUSH, WORD_MIN, 0);
        send_command(OP_SWAP, 0, 0);
        send_command(OP_DIVMOD, 0, 0);
        send_command(OP_PUSH, WORD_M1, 0);
        send_command(OP_DIV, 0, 0);
        send_command(OP_PUSH, WORD_M1, 0);
        send_command(OP_DIVMOD, 0, 0);
        send_command(OP_PUSH, 0, 0);
        send_command(OP_DIV, 0, 0);
        send_command(OP_DIVMOD, 0, 0);
        send_command(OP_SPARE_B, 0, 0);
        send_command(OP_SWAP, 0, 0);
        send_command(OP_MUL, 0, 0);
        send_command(OP_PUSH, WORD_MAX, 0);
        send_command(OP_SUB, 0, 0);
        send_command(OP_PUSH, WORD_MAX, 0);
        send_command(OP_ADD, 0, 0);
        send_command(OP_DUP, 0, 0);
        send_command(OP_GT, 0, 0);
        send_command(OP_PUSH, WORD_MIN, 0);
        send_command(OP_GE, 0, 0);
        send_command(OP_PUSH, 1, 0);
        send_command(OP_LT, 0, 0);
        send_command(OP_PUSH, 0, 0);
        send_command(OP_LE, 0, 0);
        send_command(OP_PUSH, 1, 0);
        send_command(OP_EQ, 0, 0);
        send_command(OP_POP, 0, 0);
        // fill the stack, then push and dup must report overflow
        while (mirror.entries < STACK_DEPTH)
            send_command(OP_PUSH, $urandom, 0);
        send_command(OP_PUSH, WORD_MAX, 0);
        send_command(OP_DUP, 0, 0);
        wait_results_drained();

        // Random: weighted commands, with an occasional run to a full stack.
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if ($urandom_range(0, 59) == 0) begin
                while (mirror.entries < STACK_DEPTH)
                    send_command(OP_PUSH, pick_value(), n < RANDOM_CMDS - CALM_TAIL);
                send_command($urandom_range(0, 1) ? OP_PUSH : OP_DUP, pick_value(), 0);
            end
            if ($urandom_range(0, 99) == 0 && n < RANDOM_CMDS - CALM_TAIL)
                wait_results_drained();
            op    = pick_op(mirror.entries);
            value = (op == OP_PUSH) ? pick_value() : t_word'($urandom);
            send_command(op, value, n < RANDOM_CMDS - CALM_TAIL);
        end
        start <= 1'b0;

        while (mirror.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mirror.mismatches == 0 && mirror.awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 600 items.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/scalc_pkg.sv
src/scalc_div.sv
src/scalc_dp.sv
src/scalc_ctrl.sv
src/stack_calculator_alu.sv
src/scalc_checker.sv
sim/tb_stack_calculator_alu.sv
